### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define OBM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle outside reset.
`define OBM_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

### rtl/obm_pkg.sv
// Types and constants of the obstacle and battery monitor.
`default_nettype none

package obm_pkg;

   localparam int unsigned WINDOW   = 20;
   localparam int unsigned ID_W     = 32;
   localparam int unsigned DIST_W   = 16;
   localparam int unsigned ADC_W    = 12;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned TOTAL_W  = 17;
   localparam int unsigned SCALE_W  = TOTAL_W + 1;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_OBSTACLE_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_LOW_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BATTERY_FLOOR      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_CEILING     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBSTITUTE_VALUE   = 3'd4;

   localparam logic [DIST_W-1:0] RST_OBSTACLE_THRESHOLD = 16'd30;
   localparam logic [ADC_W-1:0]  RST_BATTERY_LOW_LIMIT  = 12'd2600;
   localparam logic [ADC_W-1:0]  RST_BATTERY_FLOOR      = 12'd700;
   localparam logic [ADC_W-1:0]  RST_SAMPLE_CEILING     = 12'd4000;
   localparam logic [ADC_W-1:0]  RST_SUBSTITUTE_VALUE   = 12'd3300;

   localparam logic [1:0] SIDE_FRONT = 2'd0;
   localparam logic [1:0] SIDE_LEFT  = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;

   typedef struct packed {
      logic [DIST_W-1:0] obstacle_threshold;
      logic [ADC_W-1:0]  battery_low_limit;
      logic [ADC_W-1:0]  battery_floor;
      logic [ADC_W-1:0]  sample_ceiling;
      logic [ADC_W-1:0]  substitute_value;
   } cfg_type;

   typedef struct packed {
      logic [ID_W-1:0]   seq_id;
      logic              with_distances;
      logic [DIST_W-1:0] front_distance;
      logic [DIST_W-1:0] left_distance;
      logic [DIST_W-1:0] right_distance;
      logic [ADC_W-1:0]  battery_sample;
   } req_type;

   typedef struct packed {
      logic               pending_obstacle;
      logic [ID_W-1:0]    last_seq_id;
      logic [COUNT_W-1:0] window_count;
      logic [TOTAL_W-1:0] window_total;
   } state_type;

   typedef struct packed {
      logic       fresh_packet;
      logic       obstacle_event;
      logic [1:0] obstacle_side;
      logic       low_battery;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/obm_csr.sv
// Configuration registers of the obstacle and battery monitor.
`default_nettype none

module obm_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [obm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [obm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output obm_pkg::cfg_type                     cfg
);

   obm_pkg::cfg_type cfg_ff;
   obm_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            obm_pkg::CSR_OBSTACLE_THRESHOLD: cfg_in.obstacle_threshold = csr_wdata;
            obm_pkg::CSR_BATTERY_LOW_LIMIT:
               cfg_in.battery_low_limit = csr_wdata[obm_pkg::ADC_W-1:0];
            obm_pkg::CSR_BATTERY_FLOOR:
               cfg_in.battery_floor = csr_wdata[obm_pkg::ADC_W-1:0];
            obm_pkg::CSR_SAMPLE_CEILING:
               cfg_in.sample_ceiling = csr_wdata[obm_pkg::ADC_W-1:0];
            obm_pkg::CSR_SUBSTITUTE_VALUE:
               cfg_in.substitute_value = csr_wdata[obm_pkg::ADC_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.obstacle_threshold <= obm_pkg::RST_OBSTACLE_THRESHOLD;
         cfg_ff.battery_low_limit  <= obm_pkg::RST_BATTERY_LOW_LIMIT;
         cfg_ff.battery_floor      <= obm_pkg::RST_BATTERY_FLOOR;
         cfg_ff.sample_ceiling     <= obm_pkg::RST_SAMPLE_CEILING;
         cfg_ff.substitute_value   <= obm_pkg::RST_SUBSTITUTE_VALUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### rtl/obm_eval.sv
// Per-packet evaluation: freshness, obstacle debounce and battery window.
`default_nettype none

module obm_eval (
   input  wire obm_pkg::cfg_type   cfg,
   input  wire obm_pkg::req_type   req,
   input  wire obm_pkg::state_type state_cur,
   output obm_pkg::state_type      state_nxt,
   output obm_pkg::rsp_type        rsp
);

   localparam logic [obm_pkg::COUNT_W-1:0] WINDOW_CNT = obm_pkg::COUNT_W'(obm_pkg::WINDOW);
   localparam logic [obm_pkg::SCALE_W-1:0] WINDOW_K   = obm_pkg::SCALE_W'(obm_pkg::WINDOW);

   logic                         fresh;
   logic                         hit;
   logic [1:0]                   hit_side;
   logic [obm_pkg::COUNT_W-1:0]  count_inc;
   logic                         window_done;
   logic                         sample_ok;
   logic [obm_pkg::SCALE_W-1:0]  limit_scaled;
   logic [obm_pkg::SCALE_W-1:0]  floor_scaled;
   logic [obm_pkg::SCALE_W-1:0]  total_ext;
   logic [obm_pkg::ADC_W-1:0]    addend;

   always_comb begin
      fresh = req.seq_id > state_cur.last_seq_id;

      // Front wins over left, left over right.
      hit      = 1'b1;
      hit_side = obm_pkg::SIDE_FRONT;
      priority if (req.front_distance < cfg.obstacle_threshold) begin
         hit_side = obm_pkg::SIDE_FRONT;
      end else if (req.left_distance < cfg.obstacle_threshold) begin
         hit_side = obm_pkg::SIDE_LEFT;
      end else if (req.right_distance < cfg.obstacle_threshold) begin
         hit_side = obm_pkg::SIDE_RIGHT;
      end else begin
         hit = 1'b0;
      end

      count_inc   = state_cur.window_count + 1'b1;
      window_done = count_inc == WINDOW_CNT;
      sample_ok   = (req.battery_sample < cfg.sample_ceiling) &&
                    (req.battery_sample > cfg.battery_floor);
      addend      = sample_ok ? req.battery_sample : cfg.substitute_value;

      // Compare the total against scaled bounds instead of dividing.
      limit_scaled = obm_pkg::SCALE_W'(cfg.battery_low_limit) * WINDOW_K;
      floor_scaled = (obm_pkg::SCALE_W'(cfg.battery_floor) + 1'b1) * WINDOW_K;
      total_ext    = obm_pkg::SCALE_W'(state_cur.window_total);

      state_nxt = state_cur;
      rsp       = '0;

      if (fresh) begin
         rsp.fresh_packet = 1'b1;
         state_nxt.last_seq_id = req.seq_id;
         if (req.with_distances && hit) begin
            if (!state_cur.pending_obstacle) begin
               state_nxt.pending_obstacle = 1'b1;
            end else begin
               state_nxt.pending_obstacle = 1'b0;
               rsp.obstacle_event = 1'b1;
               rsp.obstacle_side  = hit_side;
            end
         end
         if (window_done) begin
            rsp.low_battery = (total_ext < limit_scaled) && (total_ext >= floor_scaled);
            state_nxt.window_total = '0;
            state_nxt.window_count = '0;
         end else begin
            state_nxt.window_count = count_inc;
            state_nxt.window_total = state_cur.window_total +
                                     obm_pkg::TOTAL_W'(addend);
         end
      end else if (req.with_distances) begin
         state_nxt.last_seq_id = req.seq_id;
      end
   end

endmodule

`default_nettype wire

### rtl/obstacle_and_battery_monitor.sv
// Top level of the obstacle and battery monitor.
// The result is registered: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while rsp_stall is low; the evaluation step between the registers sets it.
// The input register accepts a new item while a finished result waits to be taken, if it holds none itself.
// Reset is synchronous, active high: thresholds return to their defaults, the last packet
// id, debounce bit and battery window clear, and both pipeline registers empty.
`default_nettype none
`include "assert_macros.svh"

module obstacle_and_battery_monitor (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write_en,
   input  wire logic [obm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [obm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [obm_pkg::ID_W-1:0]        req_seq_id,
   input  wire logic                            req_with_distances,
   input  wire logic [obm_pkg::DIST_W-1:0]      req_front_distance,
   input  wire logic [obm_pkg::DIST_W-1:0]      req_left_distance,
   input  wire logic [obm_pkg::DIST_W-1:0]      req_right_distance,
   input  wire logic [obm_pkg::ADC_W-1:0]       req_battery_sample,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic                            rsp_fresh_packet,
   output      logic                            rsp_obstacle_event,
   output      logic [1:0]                      rsp_obstacle_side,
   output      logic                            rsp_low_battery
);

   obm_pkg::cfg_type   cfg;
   obm_pkg::req_type   req_ff;
   obm_pkg::req_type   req_in;
   obm_pkg::state_type state_ff;
   obm_pkg::state_type state_in;
   obm_pkg::rsp_type   rsp_ff;
   obm_pkg::rsp_type   rsp_in;
   logic               in_valid_ff;
   logic               in_valid_in;
   logic               out_valid_ff;
   logic               out_valid_in;
   logic               advance;
   logic               accept;

   obm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   obm_eval u_eval (
      .cfg       (cfg),
      .req       (req_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .rsp       (rsp_in)
   );

   // Move the held item into the result register when that register frees up.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      req_in.seq_id         = req_seq_id;
      req_in.with_distances = req_with_distances;
      req_in.front_distance = req_front_distance;
      req_in.left_distance  = req_left_distance;
      req_in.right_distance = req_right_distance;
      req_in.battery_sample = req_battery_sample;

      in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : ((out_valid_ff && !rsp_stall) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_fresh_packet   = rsp_ff.fresh_packet;
   assign rsp_obstacle_event = rsp_ff.obstacle_event;
   assign rsp_obstacle_side  = rsp_ff.obstacle_side;
   assign rsp_low_battery    = rsp_ff.low_battery;

   `OBM_ASSERT_IMPLIES(a_stale_quiet, rsp_valid && !rsp_fresh_packet, !rsp_obstacle_event && !rsp_low_battery, "stale packet produced an event")
   `OBM_ASSERT_IMPLIES(a_side_valid, rsp_valid && rsp_obstacle_event, rsp_obstacle_side <= obm_pkg::SIDE_RIGHT, "obstacle side out of range")
   `OBM_ASSERT_ALWAYS(a_window_bound, state_ff.window_count < obm_pkg::COUNT_W'(obm_pkg::WINDOW), "window count reached window length")
   `OBM_ASSERT_IMPLIES(a_stall_full, req_stall, in_valid_ff && out_valid_ff && rsp_stall, "input stalled without a blocked result")

endmodule

`default_nettype wire

### verif/tb_obstacle_and_battery_monitor.sv
// Self-checking testbench of the obstacle and battery monitor: directed packets, then random phases.
`timescale 1ns / 1ps

module tb_obstacle_and_battery_monitor;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 238;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_write_en = 1'b0;
   logic [obm_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [obm_pkg::CSR_DATA_W-1:0] csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [obm_pkg::ID_W-1:0]       req_seq_id = '0;
   logic                           req_with_distances = 1'b0;
   logic [obm_pkg::DIST_W-1:0]     req_front_distance = '0;
   logic [obm_pkg::DIST_W-1:0]     req_left_distance = '0;
   logic [obm_pkg::DIST_W-1:0]     req_right_distance = '0;
   logic [obm_pkg::ADC_W-1:0]      req_battery_sample = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic                           rsp_fresh_packet;
   logic                           rsp_obstacle_event;
   logic [1:0]                     rsp_obstacle_side;
   logic                           rsp_low_battery;

   obstacle_and_battery_monitor i_dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_seq_id         (req_seq_id),
      .req_with_distances (req_with_distances),
      .req_front_distance (req_front_distance),
      .req_left_distance  (req_left_distance),
      .req_right_distance (req_right_distance),
      .req_battery_sample (req_battery_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fresh_packet   (rsp_fresh_packet),
      .rsp_obstacle_event (rsp_obstacle_event),
      .rsp_obstacle_side  (rsp_obstacle_side),
      .rsp_low_battery    (rsp_low_battery)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Mirror of the block: its registers and its state.
   obm_pkg::cfg_type   model_cfg;
   obm_pkg::state_type model_state;

   obm_pkg::req_type pending_packets[$];
   obm_pkg::rsp_type expected_reports[$];

   logic idle_on = 1'b1;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;
   int   send_gap = 0;
   int   rsp_hold = 0;
   int   cycle_count = 0;
   int   mismatches = 0;
   int   packets_sent = 0;
   int   reports_checked = 0;
   int   stale_seen = 0;
   int   events_seen = 0;
   int   lows_seen = 0;

   function automatic int draw_wait();
      if (!idle_on) return 0;
      return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 8));
   endfunction

   function automatic obm_pkg::rsp_type evaluate_packet(obm_pkg::req_type pkt);
      obm_pkg::rsp_type           rep;
      logic [obm_pkg::DIST_W-1:0] reading [3];
      logic [1:0]                 side_code [3];
      logic                       hit;
      int unsigned                avg;
      rep = '0;
      hit = 1'b0;
      reading[0] = pkt.front_distance;
      reading[1] = pkt.left_distance;
      reading[2] = pkt.right_distance;
      side_code[0] = obm_pkg::SIDE_FRONT;
      side_code[1] = obm_pkg::SIDE_LEFT;
      side_code[2] = obm_pkg::SIDE_RIGHT;
      if (pkt.seq_id > model_state.last_seq_id) begin
         rep.fresh_packet = 1'b1;
         if (pkt.with_distances) begin
            // first side below threshold wins; one shared debounce bit
            for (int k = 0; k < 3; k++) begin
               if (!hit && reading[k] < model_cfg.obstacle_threshold) begin
                  hit = 1'b1;
                  if (!model_state.pending_obstacle) begin
                     model_state.pending_obstacle = 1'b1;
                  end else begin
                     model_state.pending_obstacle = 1'b0;
                     rep.obstacle_event = 1'b1;
                     rep.obstacle_side = side_code[k];
                  end
               end
            end
         end
         model_state.window_count = model_state.window_count + 1'b1;
         if (model_state.window_count == obm_pkg::COUNT_W'(obm_pkg::WINDOW)) begin
            // closing sample is dropped, not added
            avg = model_state.window_total / obm_pkg::WINDOW;
            if (avg < model_cfg.battery_low_limit && avg > model_cfg.battery_floor)
               rep.low_battery = 1'b1;
            model_state.window_total = '0;
            model_state.window_count = '0;
         end else if (pkt.battery_sample < model_cfg.sample_ceiling &&
                      pkt.battery_sample > model_cfg.battery_floor) begin
            model_state.window_total = model_state.window_total +
                                       obm_pkg::TOTAL_W'(pkt.battery_sample);
         end else begin
            model_state.window_total = model_state.window_total +
                                       obm_pkg::TOTAL_W'(model_cfg.substitute_value);
         end
         model_state.last_seq_id = pkt.seq_id;
      end else if (pkt.with_distances) begin
         model_state.last_seq_id = pkt.seq_id;
      end
      return rep;
   endfunction

   task automatic write_reg(input logic [obm_pkg::CSR_IDX_W-1:0] idx,
                            input logic [obm_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         obm_pkg::CSR_OBSTACLE_THRESHOLD: model_cfg.obstacle_threshold = data;
         obm_pkg::CSR_BATTERY_LOW_LIMIT:
            model_cfg.battery_low_limit = data[obm_pkg::ADC_W-1:0];
         obm_pkg::CSR_BATTERY_FLOOR:
            model_cfg.battery_floor = data[obm_pkg::ADC_W-1:0];
         obm_pkg::CSR_SAMPLE_CEILING:
            model_cfg.sample_ceiling = data[obm_pkg::ADC_W-1:0];
         obm_pkg::CSR_SUBSTITUTE_VALUE:
            model_cfg.substitute_value = data[obm_pkg::ADC_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Upper bits of the 12-bit registers carry junk that the block must drop.
   task automatic apply_config(input logic [obm_pkg::DIST_W-1:0] thr,
                               input logic [obm_pkg::ADC_W-1:0] low,
                               input logic [obm_pkg::ADC_W-1:0] flr,
                               input logic [obm_pkg::ADC_W-1:0] ceil,
                               input logic [obm_pkg::ADC_W-1:0] subst);
      write_reg(obm_pkg::CSR_OBSTACLE_THRESHOLD, thr);
      write_reg(obm_pkg::CSR_BATTERY_LOW_LIMIT, {4'($urandom), low});
      write_reg(obm_pkg::CSR_BATTERY_FLOOR, {4'($urandom), flr});
      write_reg(obm_pkg::CSR_SAMPLE_CEILING, {4'($urandom), ceil});
      write_reg(obm_pkg::CSR_SUBSTITUTE_VALUE, {4'($urandom), subst});
   endtask

   task automatic add_packet(input logic [obm_pkg::ID_W-1:0] id, input logic with_dist,
                             input logic [obm_pkg::DIST_W-1:0] f,
                             input logic [obm_pkg::DIST_W-1:0] l,
                             input logic [obm_pkg::DIST_W-1:0] r,
                             input logic [obm_pkg::ADC_W-1:0] s);
      pending_packets.push_back('{id, with_dist, f, l, r, s});
   endtask

   // Hold until all queued packets are sent and all expected reports are checked.
   task automatic drain();
      while (pending_packets.size() != 0 || req_valid || expected_reports.size() != 0)
         @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("tb: failure");
         $finish;
      end
   end

   // Accepted items are predicted on the edge that takes them.
   always @(posedge clock) begin
      req_fire <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_reports.push_back(evaluate_packet({req_seq_id, req_with_distances,
            req_front_distance, req_left_distance, req_right_distance, req_battery_sample}));
         packets_sent++;
      end
   end

   always @(negedge clock) begin
      logic             drive_valid;
      obm_pkg::req_type next_pkt;
      drive_valid = req_valid;
      if (req_valid && req_fire) begin
         drive_valid = 1'b0;
         send_gap = draw_wait();
      end
      if (!reset && !drive_valid) begin
         if (send_gap != 0) begin
            send_gap--;
         end else if (pending_packets.size() != 0) begin
            next_pkt = pending_packets.pop_front();
            req_seq_id <= next_pkt.seq_id;
            req_with_distances <= next_pkt.with_distances;
            req_front_distance <= next_pkt.front_distance;
            req_left_distance <= next_pkt.left_distance;
            req_right_distance <= next_pkt.right_distance;
            req_battery_sample <= next_pkt.battery_sample;
            drive_valid = 1'b1;
         end
      end
      req_valid <= drive_valid;
   end

   always @(negedge clock) begin
      if (rsp_fire) rsp_hold = draw_wait();
      rsp_stall <= (rsp_hold != 0);
      if (rsp_valid && rsp_hold != 0) rsp_hold--;
   end

   always @(posedge clock) begin
      obm_pkg::rsp_type want;
      rsp_fire <= !reset && rsp_valid && !rsp_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $display("%0t: unexpected item, actual fresh %0d event %0d side %0d low %0d",
                     $time, rsp_fresh_packet, rsp_obstacle_event, rsp_obstacle_side,
                     rsp_low_battery);
            mismatches++;
         end else begin
            want = expected_reports.pop_front();
            reports_checked++;
            if (!want.fresh_packet) stale_seen++;
            if (want.obstacle_event) events_seen++;
            if (want.low_battery) lows_seen++;
            if (rsp_fresh_packet !== want.fresh_packet) begin
               $display("%0t: fresh_packet expected %0d actual %0d",
                        $time, want.fresh_packet, rsp_fresh_packet);
               mismatches++;
            end
            if (rsp_obstacle_event !== want.obstacle_event) begin
               $display("%0t: obstacle_event expected %0d actual %0d",
                        $time, want.obstacle_event, rsp_obstacle_event);
               mismatches++;
            end
            if (rsp_obstacle_side !== want.obstacle_side) begin
               $display("%0t: obstacle_side expected %0d actual %0d",
                        $time, want.obstacle_side, rsp_obstacle_side);
               mismatches++;
            end
            if (rsp_low_battery !== want.low_battery) begin
               $display("%0t: low_battery expected %0d actual %0d",
                        $time, want.low_battery, rsp_low_battery);
               mismatches++;
            end
         end
      end
   end

   initial begin
      logic [obm_pkg::ID_W-1:0]   gen_last;
      logic [obm_pkg::ID_W-1:0]   room;
      logic [obm_pkg::ID_W-1:0]   id;
      logic                       with_dist;
      logic [obm_pkg::DIST_W-1:0] side_val [3];
      logic [obm_pkg::ADC_W-1:0]  sample;
      int                         level;
      int                         pick;
      int                         tmp;
      logic [obm_pkg::ADC_W-1:0]  flr;
      logic [obm_pkg::ADC_W-1:0]  low;
      logic [obm_pkg::ADC_W-1:0]  ceil;

      model_cfg = '{obm_pkg::RST_OBSTACLE_THRESHOLD, obm_pkg::RST_BATTERY_LOW_LIMIT,
                    obm_pkg::RST_BATTERY_FLOOR, obm_pkg::RST_SAMPLE_CEILING,
                    obm_pkg::RST_SUBSTITUTE_VALUE};
      model_state = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(negedge clock);

      // Directed packets at reset settings.
      add_packet(0, 1, 0, 0, 0, 1500);            // stale at reset id, last id stays 0
      add_packet(1, 0, 0, 0, 0, 0);               // battery only, sample below floor
      add_packet(1, 0, 0, 0, 0, 4095);            // stale without distances
      add_packet(2, 1, 5, 100, 100, 700);         // arm debounce; sample at floor
      add_packet(3, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 701);  // clear readings keep the bit
      add_packet(4, 0, 0, 0, 0, 3999);            // no distances, bit unchanged
      add_packet(5, 1, 100, 10, 0, 4000);         // left event
      add_packet(6, 1, 30, 30, 29, 1500);         // at threshold is not below
      add_packet(7, 1, 31, 16'hFFFF, 0, 1500);    // right event
      add_packet(8, 1, 29, 0, 0, 1500);
      add_packet(9, 1, 0, 16'hFFFF, 16'hFFFF, 1500);  // front event
      add_packet(10, 1, 0, 0, 0, 1500);
      add_packet(9, 1, 0, 0, 0, 1500);            // stale, id moves back
      add_packet(10, 1, 0, 0, 0, 1500);
      add_packet(32'hFFFF_FFFF, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4095);
      add_packet(32'hFFFF_FFFF, 1, 0, 0, 0, 1500);
      add_packet(11, 0, 0, 0, 0, 1500);
      add_packet(11, 1, 0, 0, 0, 1500);
      // fill and close the first window
      for (int k = 0; k < 8; k++)
         add_packet(12 + k, 0, 16'($urandom), 16'($urandom), 16'($urandom), 1500);
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         idle_on = (ph % 3) != 2;
         case (ph)
            0: apply_config(16'hFFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
            1: apply_config(16'h0000, 12'h000, 12'h000, 12'h000, 12'h000);
            2: apply_config(obm_pkg::RST_OBSTACLE_THRESHOLD, obm_pkg::RST_BATTERY_LOW_LIMIT,
                            obm_pkg::RST_BATTERY_FLOOR, obm_pkg::RST_SAMPLE_CEILING,
                            obm_pkg::RST_SUBSTITUTE_VALUE);
            3: apply_config(16'h0001, 12'hFFF, 12'h000, 12'hFFF, 12'h000);
            default: begin
               flr = 12'($urandom_range(0, 1500));
               low = 12'($urandom_range(flr, 4095));
               ceil = 12'($urandom_range(low, 4095));
               apply_config(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                        : 16'($urandom_range(1, 300)),
                            low, flr, ceil, 12'($urandom));
            end
         endcase
         gen_last = model_state.last_seq_id;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0) level = int'($urandom_range(0, 4095));
            pick = int'($urandom_range(0, 99));
            if (gen_last == '1 || pick < 5) begin
               // stale with distances pulls the id back
               id = $urandom_range(0, gen_last);
               with_dist = 1'b1;
               gen_last = id;
            end else if (pick < 12) begin
               id = $urandom_range(0, gen_last);
               with_dist = $urandom_range(0, 1) == 0;
               if (with_dist) gen_last = id;
            end else begin
               room = 32'hFFFF_FFFF - gen_last;
               if (pick < 15) id = gen_last + $urandom_range(1, room);
               else id = gen_last + $urandom_range(1, (room < 4) ? room : 4);
               with_dist = $urandom_range(0, 4) != 0;
               gen_last = id;
            end
            for (int k = 0; k < 3; k++) begin
               tmp = int'($urandom_range(0, 9));
               if (tmp < 3 && model_cfg.obstacle_threshold != 0)
                  side_val[k] = 16'($urandom_range(0, model_cfg.obstacle_threshold - 1));
               else if (tmp < 5)
                  side_val[k] = model_cfg.obstacle_threshold;
               else
                  side_val[k] = 16'($urandom);
            end
            tmp = int'($urandom_range(0, 9));
            if (tmp < 6) begin
               tmp = level + int'($urandom_range(0, 64)) - 32;
               sample = (tmp < 0) ? 12'd0 : (tmp > 4095) ? 12'hFFF : 12'(tmp);
            end else if (tmp == 6) begin
               sample = model_cfg.battery_floor;
            end else if (tmp == 7) begin
               sample = model_cfg.sample_ceiling;
            end else if (tmp == 8) begin
               sample = 12'($urandom);
            end else begin
               sample = $urandom_range(0, 1) ? model_cfg.battery_floor + 1'b1
                                             : model_cfg.sample_ceiling - 1'b1;
            end
            add_packet(id, with_dist, side_val[0], side_val[1], side_val[2], sample);
         end
         drain();
      end

      $display("summary: %0d packets in %0d phases, %0d reports checked, %0d stale",
               packets_sent, PHASES + 1, reports_checked, stale_seen);
      $display("summary: %0d obstacle events, %0d low-battery windows, %0d mismatches",
               events_seen, lows_seen, mismatches);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
